// ===== hw/rtl/cmb_pkg.sv =====
// Shared types and constants for the colormap and blend pixel pipeline.
package cmb_pkg;

    // Unit level in .16 fixed point; larger levels saturate here.
    localparam logic [16:0] LEVEL_ONE = 17'd65536;

    // Segment bounds of the smooth colorwheel (one seventh of unit each).
    localparam logic [16:0] SEG_T1 = 17'd9363;
    localparam logic [16:0] SEG_T2 = 17'd18725;
    localparam logic [16:0] SEG_T3 = 17'd28087;
    localparam logic [16:0] SEG_T4 = 17'd37450;
    localparam logic [16:0] SEG_T5 = 17'd46812;
    localparam logic [16:0] SEG_T6 = 17'd56174;

    // Offsets against 7*level inside the smooth colorwheel (subtracted from it, or it from them).
    localparam logic [19:0] SEG_K1 = 20'd65536;
    localparam logic [19:0] SEG_K3 = 20'd196608;
    localparam logic [19:0] SEG_K5 = 20'd327680;
    localparam logic [19:0] SEG_K6 = 20'd393216;

    localparam logic [7:0] MAP_GAIN = 8'd255;

    localparam logic FAMILY_GRADIENT = 1'b0;
    localparam logic FAMILY_SOLID    = 1'b1;

    // Gradient family modes
    localparam logic [3:0] GRAD_SMOOTH    = 4'd0;
    localparam logic [3:0] GRAD_SCALLOP   = 4'd1;
    localparam logic [3:0] GRAD_GRAY      = 4'd2;
    localparam logic [3:0] GRAD_RED       = 4'd3;
    localparam logic [3:0] GRAD_GREEN     = 4'd4;
    localparam logic [3:0] GRAD_BLUE      = 4'd5;
    localparam logic [3:0] GRAD_RED_OVL   = 4'd6;
    localparam logic [3:0] GRAD_GREEN_OVL = 4'd7;
    localparam logic [3:0] GRAD_BLUE_OVL  = 4'd8;

    // Solid-alpha family modes
    localparam logic [3:0] SOLID_BLACK  = 4'd0;
    localparam logic [3:0] SOLID_RED    = 4'd1;
    localparam logic [3:0] SOLID_GREEN  = 4'd2;
    localparam logic [3:0] SOLID_BLUE   = 4'd3;
    localparam logic [3:0] SOLID_YELLOW = 4'd4;
    localparam logic [3:0] SOLID_CYAN   = 4'd5;
    localparam logic [3:0] SOLID_PURPLE = 4'd6;
    localparam logic [3:0] SOLID_GRAY   = 4'd7;
    localparam logic [3:0] SOLID_WHITE  = 4'd8;

    // Configuration register indexes
    localparam logic CFG_FAMILY = 1'b0;
    localparam logic CFG_MODE   = 1'b1;

    typedef struct packed {
        logic       family;
        logic [3:0] mode;
    } map_cfg_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pm_color_t;

    typedef struct packed {
        logic      overlay;
        pm_color_t color;
        logic [23:0] bg;
    } blend_req_t;

endpackage

// ===== hw/rtl/colormap_and_blend_pixel.sv =====
// Colormap lookup and premultiplied blend of one pixel per request.
// Maps a signed .16 level through the colormap chosen by map_family and
// map_mode, then blends the premultiplied color onto the background pixel
// (over operator, or clamped additive overlay for the overlay gradients).
// One request is accepted per clock while the pipeline is not stalled; each
// result passes three stages for level clamp, segment terms and the
// gain-255 products with color selection, then two for the per-channel
// blend multiply and the rounding/clamp into the output register. Stalls
// back up stage by stage, so empty stages keep accepting.
// Negative levels and inactive modes (9..15) return the background.
// Configuration writes are always accepted (cfg_ready stays high) and must
// only happen while no request is in flight.
module colormap_and_blend_pixel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // level[17:0], bg_pixel[41:18], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_pixel[23:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    import cmb_pkg::*;

    logic       map_family_reg;
    logic [3:0] map_mode_reg;
    map_cfg_t   cfg;

    logic       req_valid, req_ready;
    blend_req_t req;

    assign cfg_ready  = 1'b1;
    assign cfg.family = map_family_reg;
    assign cfg.mode   = map_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_family_reg <= FAMILY_GRADIENT;
            map_mode_reg   <= GRAD_SMOOTH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FAMILY: map_family_reg <= cfg_data[0];
                CFG_MODE:   map_mode_reg   <= cfg_data;
                default:    map_mode_reg   <= map_mode_reg;
            endcase
        end
    end

    cmb_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .level     (s_tdata[17:0]),
        .bg_pixel  (s_tdata[41:18]),
        .out_valid (req_valid),
        .out_ready (req_ready),
        .out_req   (req)
    );

    cmb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (m_tvalid),
        .pix_ready (m_tready),
        .pixel     (m_tdata)
    );

endmodule

// ===== hw/rtl/cmb_map.sv =====
// Level clamp and colormap lookup: three pipeline stages giving a premultiplied color.
module cmb_map (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmb_pkg::map_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [17:0]  level,
    input  logic [23:0]         bg_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output cmb_pkg::blend_req_t out_req
);
    import cmb_pkg::*;

    // (x * 255) >> 16 for x up to unit level
    function automatic logic [7:0] gain_hi(input logic [16:0] x);
        logic [24:0] p;
        p = ({8'd0, x} << 8) - {8'd0, x};
        return p[23:16];
    endfunction

    // stage A: clamped level
    logic        a_valid_reg;
    logic [16:0] a_v_reg;
    logic        a_neg_reg;
    logic [23:0] a_bg_reg;

    // stage B: segment and fraction terms
    logic        b_valid_reg;
    logic [2:0]  b_seg_reg;
    logic [16:0] b_sdiff_reg;
    logic [3:0]  b_cat_reg;
    logic [15:0] b_frac_reg;
    logic [16:0] b_v_reg;
    logic        b_neg_reg;
    logic [23:0] b_bg_reg;

    // stage C: mapped color
    logic        c_valid_reg;
    blend_req_t  c_req_reg;

    logic a_ready, b_ready, c_ready;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign out_valid = c_valid_reg;
    assign out_req   = c_req_reg;

    // ---- stage A input logic
    logic [16:0] v_clamp;

    always_comb begin
        if (level[17]) begin
            v_clamp = 17'd0;
        end else if (level[16:0] > LEVEL_ONE) begin
            v_clamp = LEVEL_ONE;
        end else begin
            v_clamp = level[16:0];
        end
    end

    // ---- stage B input logic
    logic [19:0] v_ext, v7, cat, diff;
    logic [2:0]  seg;

    always_comb begin
        v_ext = {3'd0, a_v_reg};
        v7    = (v_ext << 3) - v_ext;
        cat   = (v_ext << 3) + (v_ext << 2);
        if (a_v_reg < SEG_T1)      seg = 3'd0;
        else if (a_v_reg < SEG_T2) seg = 3'd1;
        else if (a_v_reg < SEG_T3) seg = 3'd2;
        else if (a_v_reg < SEG_T4) seg = 3'd3;
        else if (a_v_reg < SEG_T5) seg = 3'd4;
        else if (a_v_reg < SEG_T6) seg = 3'd5;
        else                       seg = 3'd6;
        case (seg)
            3'd0:    diff = v7;
            3'd1:    diff = v7 - SEG_K1;
            3'd2:    diff = SEG_K3 - v7;
            3'd3:    diff = v7 - SEG_K3;
            3'd4:    diff = SEG_K5 - v7;
            3'd5:    diff = v7 - SEG_K5;
            default: diff = v7 - SEG_K6;
        endcase
    end

    // ---- stage C input logic
    logic [7:0]  sm, f, s;
    logic [9:0]  f3, f3r;
    logic [7:0]  f3q;
    pm_color_t   col;
    logic        overlay;

    always_comb begin
        sm  = gain_hi(b_sdiff_reg);
        f   = gain_hi({1'b0, b_frac_reg});
        s   = gain_hi(b_v_reg);
        f3  = ({2'd0, f} << 1) + {2'd0, f};
        f3r = f3 + 10'd2;
        f3q = f3[9:2];
        col = '0;
        if (cfg.family == FAMILY_GRADIENT) begin
            col.a = MAP_GAIN;
            case (cfg.mode) inside
                GRAD_SMOOTH: begin
                    case (b_seg_reg)
                        3'd0: col.b = sm;
                        3'd1: begin col.g = sm; col.b = MAP_GAIN; end
                        3'd2: begin col.g = MAP_GAIN; col.b = sm; end
                        3'd3: begin col.g = MAP_GAIN; col.r = sm; end
                        3'd4: begin col.g = sm; col.r = MAP_GAIN; end
                        3'd5: begin col.b = sm; col.r = MAP_GAIN; end
                        default: begin
                            col.g = sm;
                            col.r = MAP_GAIN;
                            col.b = MAP_GAIN;
                        end
                    endcase
                end
                GRAD_SCALLOP: begin
                    case (b_cat_reg)
                        4'd0:  begin col.r = {2'd0, f[7:2]}; col.b = f3q; end
                        4'd1:  col.b = f;
                        4'd2:  begin col.g = f3q; col.b = f; end
                        4'd3:  begin col.g = f; col.b = f3q; end
                        4'd4:  begin col.g = f; col.b = {2'd0, f[7:2]}; end
                        4'd5:  begin col.r = {1'b0, f[7:1]}; col.g = f; end
                        4'd6:  begin col.r = f; col.g = f; end
                        4'd7:  begin col.r = f; col.g = {1'b0, f[7:1]}; end
                        4'd8:  col.r = f;
                        4'd9:  begin col.r = f; col.b = f3r[9:2]; end
                        4'd10: begin col.r = f; col.g = f3q; col.b = f; end
                        4'd11: begin col.r = f; col.g = f; col.b = f; end
                        default: begin
                            col.r = MAP_GAIN;
                            col.g = MAP_GAIN;
                            col.b = MAP_GAIN;
                        end
                    endcase
                end
                GRAD_GRAY: begin col.r = s; col.g = s; col.b = s; end
                GRAD_RED, GRAD_RED_OVL:     col.r = s;
                GRAD_GREEN, GRAD_GREEN_OVL: col.g = s;
                GRAD_BLUE, GRAD_BLUE_OVL:   col.b = s;
                default: col.a = 8'd0;
            endcase
        end else begin
            col.a = s;
            case (cfg.mode)
                SOLID_BLACK:  col.a = s;
                SOLID_RED:    col.r = s;
                SOLID_GREEN:  col.g = s;
                SOLID_BLUE: begin
                    col.r = {4'd0, s[7:4]};
                    col.g = {4'd0, s[7:4]};
                    col.b = s;
                end
                SOLID_YELLOW: begin col.r = s; col.g = s; end
                SOLID_CYAN:   begin col.g = s; col.b = s; end
                SOLID_PURPLE: begin col.r = s; col.b = s; end
                SOLID_GRAY: begin
                    col.r = {1'b0, s[7:1]};
                    col.g = {1'b0, s[7:1]};
                    col.b = {1'b0, s[7:1]};
                end
                SOLID_WHITE:  begin col.r = s; col.g = s; col.b = s; end
                default:      col.a = 8'd0;
            endcase
        end
        // negative level maps nothing: zero alpha leaves the background
        if (b_neg_reg) begin
            col = '0;
        end
        overlay = (cfg.family == FAMILY_GRADIENT) &&
                  ((cfg.mode == GRAD_RED_OVL) || (cfg.mode == GRAD_GREEN_OVL) ||
                   (cfg.mode == GRAD_BLUE_OVL));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_v_reg   <= v_clamp;
            a_neg_reg <= level[17];
            a_bg_reg  <= bg_pixel;
        end
        if (b_ready && a_valid_reg) begin
            b_seg_reg   <= seg;
            b_sdiff_reg <= diff[16:0];
            b_cat_reg   <= cat[19:16];
            b_frac_reg  <= cat[15:0];
            b_v_reg     <= a_v_reg;
            b_neg_reg   <= a_neg_reg;
            b_bg_reg    <= a_bg_reg;
        end
        if (c_ready && b_valid_reg) begin
            c_req_reg.overlay <= overlay;
            c_req_reg.color   <= col;
            c_req_reg.bg      <= b_bg_reg;
        end
    end

endmodule

// ===== hw/rtl/cmb_blend.sv =====
// Blend of the mapped color onto the background: over operator or additive overlay.
module cmb_blend (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  cmb_pkg::blend_req_t req,
    output logic                pix_valid,
    input  logic                pix_ready,
    output logic [23:0]         pixel
);
    import cmb_pkg::*;

    // stage D: products and overlay sums
    logic            d_valid_reg;
    logic [2:0][15:0] d_prod_reg;
    logic [2:0][8:0]  d_osum_reg;
    logic [2:0][7:0]  d_src_reg;
    logic            d_overlay_reg;

    // stage E: output register
    logic            e_valid_reg;
    logic [23:0]     e_pixel_reg;

    logic d_ready, e_ready;

    assign e_ready   = !e_valid_reg || pix_ready;
    assign d_ready   = !d_valid_reg || e_ready;
    assign req_ready = d_ready;
    assign pix_valid = e_valid_reg;
    assign pixel     = e_pixel_reg;

    // channel 2 red, 1 green, 0 blue
    logic [2:0][7:0]  bg_ch, src_ch;
    logic [7:0]       sa;
    logic [2:0][15:0] prod;
    logic [2:0][8:0]  osum;

    always_comb begin
        bg_ch  = req.bg;
        src_ch = {req.color.r, req.color.g, req.color.b};
        sa     = ~req.color.a;
        for (int i = 0; i < 3; i++) begin
            prod[i] = 16'(bg_ch[i]) * 16'(sa) + 16'd128;
            osum[i] = {1'b0, bg_ch[i]} + {1'b0, src_ch[i]};
        end
    end

    logic [2:0][16:0] rnd;
    logic [2:0][8:0]  over_sum;
    logic [2:0][7:0]  over_px;
    logic [2:0][8:0]  ex_full;
    logic [2:0][7:0]  ex;
    logic [2:0][8:0]  others;
    logic [2:0][10:0] odiff;
    logic [2:0][7:0]  ovl_px;
    logic [23:0]      pix_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // divide by 255 with rounding
            rnd[i]      = {1'b0, d_prod_reg[i]} + {9'd0, d_prod_reg[i][15:8]};
            over_sum[i] = {1'b0, rnd[i][15:8]} + {1'b0, d_src_reg[i]};
            over_px[i]  = over_sum[i][8] ? MAP_GAIN : over_sum[i][7:0];
            ex_full[i]  = d_osum_reg[i] - {1'b0, MAP_GAIN};
            ex[i]       = d_osum_reg[i][8] ? ex_full[i][7:0] : 8'd0;
        end
        // spill of each channel is taken from the other two
        others[0] = {1'b0, ex[1]} + {1'b0, ex[2]};
        others[1] = {1'b0, ex[0]} + {1'b0, ex[2]};
        others[2] = {1'b0, ex[0]} + {1'b0, ex[1]};
        for (int i = 0; i < 3; i++) begin
            odiff[i] = {2'd0, d_osum_reg[i]} - {2'd0, others[i]};
            if (odiff[i][10]) begin
                ovl_px[i] = 8'd0;
            end else if (odiff[i][9:8] != 2'd0) begin
                ovl_px[i] = MAP_GAIN;
            end else begin
                ovl_px[i] = odiff[i][7:0];
            end
        end
        pix_next = d_overlay_reg ? ovl_px : over_px;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= req_valid;
            end
            if (e_ready) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && req_valid) begin
            d_prod_reg    <= prod;
            d_osum_reg    <= osum;
            d_src_reg     <= src_ch;
            d_overlay_reg <= req.overlay;
        end
        if (e_ready && d_valid_reg) begin
            e_pixel_reg <= pix_next;
        end
    end

endmodule

// ===== hw/rtl/cmb_chk.sv =====
// Port-level checker for the colormap and blend pipeline, bound to the top level.
module cmb_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a free output never throttles the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // pipeline drains: a run of free output cycles with no accepted request leaves nothing to send
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(s_tvalid && s_tready, 1) && !$past(s_tvalid && s_tready, 2) &&
        !$past(s_tvalid && s_tready, 3) && !$past(s_tvalid && s_tready, 4) &&
        !$past(s_tvalid && s_tready, 5) && !$past(s_tvalid && s_tready, 6) &&
        $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) &&
        $past(m_tready, 4) && $past(m_tready, 5) && $past(m_tready, 6)
        |-> !m_tvalid)
        else $error("result with no request in flight");

endmodule

bind colormap_and_blend_pixel cmb_chk u_cmb_chk (.*);
